/* rtl/baro_pressure_temp_compensation_defines.svh */
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_defines
// assertion macros for the barometer compensation checker
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define BPTC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bptc assertion failed");

// next-cycle implication, clocked on clk, off during rst
`define BPTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bptc assertion failed");

`endif

/* rtl/bptc_pkg.sv */
// ----------------------------------------------------------------------------
// bptc_pkg
// widths, register map and constants of the barometer compensation block
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 6;
  localparam int REG_IDX_W  = 3;
  localparam int COEF_W     = 48;
  localparam int OSR_W      = 3;
  localparam int RAW_W      = 24;
  localparam int RECIP_W    = 14;
  localparam int SCL_W      = 38;
  localparam int CPROD_W    = 54;
  localparam int A_W        = 54;
  localparam int B_W        = 58;
  localparam int TP_W       = 44;
  localparam int C1S_W      = 20;
  localparam int TT_W       = 28;
  localparam int TSUM_W     = 29;
  localparam int ACC_W      = 64;
  localparam int TEMP_W     = 16;
  localparam int PRESS_W    = 32;
  localparam int PIPE_DEPTH = 10;
  localparam int C0_SHIFT   = 7;
  localparam int PRESS_FRAC = 6;

  localparam logic [OSR_W-1:0] TEMP_OSR_RST  = 3'd3;
  localparam logic [OSR_W-1:0] PRESS_OSR_RST = 3'd6;

  localparam logic [63:0] SCALE_K [8] = '{
    64'd524288, 64'd1572864, 64'd3670016, 64'd7864320,
    64'd253952, 64'd516096,  64'd1040384, 64'd2088960
  };

  localparam logic signed [TEMP_W-1:0]  TEMP_MAX  = 16'sh7fff;
  localparam logic signed [TEMP_W-1:0]  TEMP_MIN  = 16'sh8000;
  localparam logic signed [PRESS_W-1:0] PRESS_MAX = 32'sh7fffffff;
  localparam logic signed [PRESS_W-1:0] PRESS_MIN = 32'sh80000000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_LOW  = 3'd0,
    REG_COEF_MID  = 3'd1,
    REG_COEF_HIGH = 3'd2,
    REG_TEMP_OSR  = 3'd3,
    REG_PRESS_OSR = 3'd4
  } reg_idx_t;

endpackage

/* rtl/bptc_mulq.sv */
// ----------------------------------------------------------------------------
// bptc_mulq
// two-stage fixed-point multiply: split partial products, then sum and
// round to nearest with ties away from zero, dropping FRAC fraction bits
// ----------------------------------------------------------------------------
module bptc_mulq #(
  parameter int AW   = 38,
  parameter int BW   = 38,
  parameter int OW   = 44,
  parameter int FRAC = 24
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [OW-1:0] res
);

  localparam int LW = BW / 2;
  localparam int HW = BW - LW;
  localparam int PW = AW + BW;

  logic signed [AW+LW:0]   pp_lo;
  logic signed [AW+HW-1:0] pp_hi;
  logic                    neg;
  logic signed [PW-1:0]    full;
  logic signed [PW-1:0]    shifted;

  // ties away from zero: add half, less one when the product is negative
  assign full = (PW'(pp_hi) <<< LW) + PW'(pp_lo) + (PW'(1) <<< (FRAC - 1)) - PW'(neg);
  assign shifted = full >>> FRAC;

  always_ff @(posedge clk) begin
    pp_lo <= a * $signed({1'b0, b[LW-1:0]});
    pp_hi <= a * $signed(b[BW-1:LW]);
    neg   <= a[AW-1] ^ b[BW-1];
    res   <= shifted[OW-1:0];
  end

endmodule

/* rtl/baro_pressure_temp_compensation.sv */
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// barometer temperature and pressure compensation pipeline
//
// Takes one raw temperature/pressure pair per clock whenever start is high
// and busy is low; busy is high only while rst is asserted. Each pair comes
// out on temperature/pressure with a one-cycle done strobe, in order, one
// result per request; done and the result are registered at the same edge.
// The output is not held and cannot be stalled: the receiver must take it in
// the done cycle. The pipeline depth is set by the pressure path: one stage
// for the oversampling scale, two for the c30 product and the add that forms
// a, two for the fixed-point product with a, one for the add that forms b,
// two for the fixed-point product with b, one for the polynomial sum and one
// for output rounding and saturation. The user must write calibration words
// and oversampling codes over the APB port only while no request is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation #(
  parameter int FRACTION_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [bptc_pkg::ADDR_W-1:0]            paddr,
  input  logic [bptc_pkg::DATA_W-1:0]            pwdata,
  output logic [bptc_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [bptc_pkg::RAW_W-1:0]      raw_temperature,
  input  logic signed [bptc_pkg::RAW_W-1:0]      raw_pressure,
  output logic                                   done,
  output logic signed [bptc_pkg::TEMP_W-1:0]     temperature,
  output logic signed [bptc_pkg::PRESS_W-1:0]    pressure
);

  import bptc_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP [8] = '{
    RECIP_W'(((64'd1 << FRACTION_BITS) + SCALE_K[0] / 2) / SCALE_K[0]),
    RECIP_W'(((64'd1 << FRACTION_BITS) + SCALE_K[1] / 2) / SCALE_K[1]),
    RECIP_W'(((64'd1 << FRACTION_BITS) + SCALE_K[2] / 2) / SCALE_K[2]),
    RECIP_W'(((64'd1 << FRACTION_BITS) + SCALE_K[3] / 2) / SCALE_K[3]),
    RECIP_W'(((64'd1 << FRACTION_BITS) + SCALE_K[4] / 2) / SCALE_K[4]),
    RECIP_W'(((64'd1 << FRACTION_BITS) + SCALE_K[5] / 2) / SCALE_K[5]),
    RECIP_W'(((64'd1 << FRACTION_BITS) + SCALE_K[6] / 2) / SCALE_K[6]),
    RECIP_W'(((64'd1 << FRACTION_BITS) + SCALE_K[7] / 2) / SCALE_K[7])
  };

  // configuration registers
  logic [COEF_W-1:0] coef_low;
  logic [COEF_W-1:0] coef_mid;
  logic [COEF_W-1:0] coef_high;
  logic [OSR_W-1:0]  temp_osr;
  logic [OSR_W-1:0]  press_osr;
  logic              cfg_wr;

  // unpacked coefficients
  logic signed [11:0]      c0;
  logic signed [11:0]      c1;
  logic signed [19:0]      c00;
  logic signed [19:0]      c10;
  logic signed [15:0]      c01;
  logic signed [15:0]      c11;
  logic signed [15:0]      c20;
  logic signed [15:0]      c21;
  logic signed [15:0]      c30;
  logic signed [C1S_W-1:0] c1s;

  // pipeline
  logic [PIPE_DEPTH-1:0]           vld;
  logic                            accept;
  logic signed [RECIP_W:0]         recip_t;
  logic signed [RECIP_W:0]         recip_p;
  logic signed [RAW_W+RECIP_W:0]   prod_t;
  logic signed [RAW_W+RECIP_W:0]   prod_p;
  logic signed [SCL_W-1:0]         t_s1;
  logic signed [SCL_W-1:0]         p_s1;
  logic signed [SCL_W-1:0]         p_s2;
  logic signed [SCL_W-1:0]         p_s3;
  logic signed [SCL_W-1:0]         p_s4;
  logic signed [SCL_W-1:0]         p_s5;
  logic signed [SCL_W-1:0]         p_s6;
  logic signed [CPROD_W-1:0]       pc30_s2;
  logic signed [CPROD_W-1:0]       pc21_s2;
  logic signed [CPROD_W-1:0]       tc01_s2;
  logic signed [CPROD_W-1:0]       tc01_s3;
  logic signed [CPROD_W-1:0]       tc01_s4;
  logic signed [CPROD_W-1:0]       tc01_s5;
  logic signed [TP_W-1:0]          tp_s3;
  logic signed [TT_W-1:0]          tt_s3;
  logic signed [A_W-1:0]           a_s3;
  logic signed [A_W-1:0]           c_s3;
  logic signed [TSUM_W-1:0]        tsum;
  logic                            tsum_fit;
  logic signed [TEMP_W-1:0]        tv_s4;
  logic signed [TEMP_W-1:0]        tv_s5;
  logic signed [TEMP_W-1:0]        tv_s6;
  logic signed [TEMP_W-1:0]        tv_s7;
  logic signed [TEMP_W-1:0]        tv_s8;
  logic signed [TEMP_W-1:0]        tv_s9;
  logic signed [B_W-1:0]           pa_s5;
  logic signed [ACC_W-1:0]         x_s5;
  logic signed [B_W-1:0]           b_s6;
  logic signed [ACC_W-1:0]         sum_s6;
  logic signed [ACC_W-1:0]         sum_s7;
  logic signed [ACC_W-1:0]         sum_s8;
  logic signed [ACC_W-1:0]         pb_s8;
  logic signed [ACC_W-1:0]         pq_s9;
  logic signed [ACC_W-1:0]         pq_rnd;
  logic signed [ACC_W-1:0]         pq_shr;
  logic                            pq_fit;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_low  <= '0;
      coef_mid  <= '0;
      coef_high <= '0;
      temp_osr  <= TEMP_OSR_RST;
      press_osr <= PRESS_OSR_RST;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:3])
        REG_COEF_LOW:  coef_low  <= pwdata[COEF_W-1:0];
        REG_COEF_MID:  coef_mid  <= pwdata[COEF_W-1:0];
        REG_COEF_HIGH: coef_high <= pwdata[COEF_W-1:0];
        REG_TEMP_OSR:  temp_osr  <= pwdata[OSR_W-1:0];
        REG_PRESS_OSR: press_osr <= pwdata[OSR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:3])
      REG_COEF_LOW:  prdata = DATA_W'(coef_low);
      REG_COEF_MID:  prdata = DATA_W'(coef_mid);
      REG_COEF_HIGH: prdata = DATA_W'(coef_high);
      REG_TEMP_OSR:  prdata = DATA_W'(temp_osr);
      REG_PRESS_OSR: prdata = DATA_W'(press_osr);
      default:       prdata = '0;
    endcase
  end

  // calibration field unpacking
  assign c0  = $signed(coef_low[47:36]);
  assign c1  = $signed(coef_low[35:24]);
  assign c00 = $signed(coef_low[23:4]);
  assign c10 = $signed({coef_low[3:0], coef_mid[47:32]});
  assign c01 = $signed(coef_mid[31:16]);
  assign c11 = $signed(coef_mid[15:0]);
  assign c20 = $signed(coef_high[47:32]);
  assign c21 = $signed(coef_high[31:16]);
  assign c30 = $signed(coef_high[15:0]);
  assign c1s = $signed({c1, 8'd0});

  // request handshake and valid chain
  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  // stage 1: oversampling scale
  assign recip_t = $signed({1'b0, RECIP[temp_osr]});
  assign recip_p = $signed({1'b0, RECIP[press_osr]});
  assign prod_t  = raw_temperature * recip_t;
  assign prod_p  = raw_pressure * recip_p;

  always_ff @(posedge clk) begin
    t_s1 <= prod_t[SCL_W-1:0];
    p_s1 <= prod_p[SCL_W-1:0];
  end

  // stages 2 and 3: first-order products
  bptc_mulq #(
    .AW(SCL_W), .BW(SCL_W), .OW(TP_W), .FRAC(FRACTION_BITS)
  ) u_mul_tp (
    .clk(clk), .a(t_s1), .b(p_s1), .res(tp_s3)
  );

  bptc_mulq #(
    .AW(SCL_W), .BW(C1S_W), .OW(TT_W), .FRAC(FRACTION_BITS)
  ) u_mul_tt (
    .clk(clk), .a(t_s1), .b(c1s), .res(tt_s3)
  );

  always_ff @(posedge clk) begin
    pc30_s2 <= p_s1 * c30;
    pc21_s2 <= p_s1 * c21;
    tc01_s2 <= t_s1 * c01;
    p_s2    <= p_s1;
    a_s3    <= (A_W'(c20) <<< FRACTION_BITS) + A_W'(pc30_s2);
    c_s3    <= (A_W'(c11) <<< FRACTION_BITS) + A_W'(pc21_s2);
    tc01_s3 <= tc01_s2;
    p_s3    <= p_s2;
  end

  // stage 4: temperature result
  assign tsum     = (TSUM_W'(c0) <<< C0_SHIFT) + TSUM_W'(tt_s3);
  assign tsum_fit = (tsum[TSUM_W-1:TEMP_W-1] == '0) || (tsum[TSUM_W-1:TEMP_W-1] == '1);

  always_ff @(posedge clk) begin
    if (tsum_fit) begin
      tv_s4 <= tsum[TEMP_W-1:0];
    end else if (tsum[TSUM_W-1]) begin
      tv_s4 <= TEMP_MIN;
    end else begin
      tv_s4 <= TEMP_MAX;
    end
  end

  // stages 4 and 5: second-order products
  bptc_mulq #(
    .AW(SCL_W), .BW(A_W), .OW(B_W), .FRAC(FRACTION_BITS)
  ) u_mul_pa (
    .clk(clk), .a(p_s3), .b(a_s3), .res(pa_s5)
  );

  bptc_mulq #(
    .AW(TP_W), .BW(A_W), .OW(ACC_W), .FRAC(FRACTION_BITS)
  ) u_mul_x (
    .clk(clk), .a(tp_s3), .b(c_s3), .res(x_s5)
  );

  always_ff @(posedge clk) begin
    tc01_s4 <= tc01_s3;
    tc01_s5 <= tc01_s4;
    p_s4    <= p_s3;
    p_s5    <= p_s4;
    tv_s5   <= tv_s4;
  end

  // stage 6: b term and partial pressure sum
  always_ff @(posedge clk) begin
    b_s6   <= (B_W'(c10) <<< FRACTION_BITS) + pa_s5;
    sum_s6 <= (ACC_W'(c00) <<< FRACTION_BITS) + ACC_W'(tc01_s5) + x_s5;
    p_s6   <= p_s5;
    tv_s6  <= tv_s5;
  end

  // stages 7 and 8: third-order product
  bptc_mulq #(
    .AW(SCL_W), .BW(B_W), .OW(ACC_W), .FRAC(FRACTION_BITS)
  ) u_mul_pb (
    .clk(clk), .a(p_s6), .b(b_s6), .res(pb_s8)
  );

  always_ff @(posedge clk) begin
    sum_s7 <= sum_s6;
    sum_s8 <= sum_s7;
    tv_s7  <= tv_s6;
    tv_s8  <= tv_s7;
  end

  // stage 9: pressure polynomial
  always_ff @(posedge clk) begin
    pq_s9 <= sum_s8 + pb_s8;
    tv_s9 <= tv_s8;
  end

  // stage 10: pressure rounding to 1/64 Pa and saturation
  assign pq_rnd = pq_s9 + (ACC_W'(1) <<< (FRACTION_BITS - PRESS_FRAC - 1))
                  - ACC_W'(pq_s9[ACC_W-1]);
  assign pq_shr = pq_rnd >>> (FRACTION_BITS - PRESS_FRAC);
  assign pq_fit = (pq_shr[ACC_W-1:PRESS_W-1] == '0) || (pq_shr[ACC_W-1:PRESS_W-1] == '1);

  always_ff @(posedge clk) begin
    temperature <= tv_s9;
    if (pq_fit) begin
      pressure <= pq_shr[PRESS_W-1:0];
    end else if (pq_shr[ACC_W-1]) begin
      pressure <= PRESS_MIN;
    end else begin
      pressure <= PRESS_MAX;
    end
  end

endmodule

/* rtl/bptc_assert.sv */
// ----------------------------------------------------------------------------
// bptc_assert
// port-level checks of request latency and register readback
// ----------------------------------------------------------------------------
`include "baro_pressure_temp_compensation_defines.svh"

module bptc_assert (
  input logic                          clk,
  input logic                          rst,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [bptc_pkg::ADDR_W-1:0]   paddr,
  input logic [bptc_pkg::DATA_W-1:0]   pwdata,
  input logic [bptc_pkg::DATA_W-1:0]   prdata,
  input logic                          start,
  input logic                          busy,
  input logic                          done
);

  import bptc_pkg::*;

  // every accepted request is followed by its done strobe
  `BPTC_ASSERT_SAME(a_req_to_done, start && !busy, ##10 done)

  // no result without a request at the matching earlier edge
  `BPTC_ASSERT_SAME(a_done_has_req, done, $past(start && !busy, 10))

  // a calibration word written reads back at the same address
  `BPTC_ASSERT_NEXT(a_coef_readback, psel && penable && pwrite && (paddr[ADDR_W-1:3] == REG_COEF_LOW || paddr[ADDR_W-1:3] == REG_COEF_MID || paddr[ADDR_W-1:3] == REG_COEF_HIGH), paddr != $past(paddr) || (prdata[COEF_W-1:0] == $past(pwdata[COEF_W-1:0]) && prdata[DATA_W-1:COEF_W] == '0))

endmodule

bind baro_pressure_temp_compensation bptc_assert u_bptc_assert (.*);
